// ----- design/alm_pkg.sv -----
// Package for the audio level bar meter.
// Holds field widths, register reset values, register indexes and the
// command/status structs shared by the controller and the datapath.
`default_nettype none

package alm_pkg;

    localparam int SAMPLE_W = 12;
    localparam int GAIN_W   = 9;
    localparam int THR_W    = 12;
    localparam int GREEN_W  = 8;
    localparam int WORD_W   = 32;
    localparam int INDEX_W  = 5;
    localparam int LEVEL_W  = 13;
    localparam int AVG_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam int COEF_W  = GAIN_W + 1;
    localparam int PROD_A_W = GAIN_W + SAMPLE_W;
    localparam int PROD_B_W = COEF_W + AVG_W;
    localparam int SUM_W   = 28;
    localparam int DIV_W   = 13;

    localparam int PIXELS_DEFAULT = 25;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 9'd358;
    localparam logic [THR_W-1:0]   THR_RESET   = 12'd2000;
    localparam logic [GREEN_W-1:0] GREEN_RESET = 8'd127;

    localparam logic [DIV_W-1:0]   FULL_SCALE  = 13'd4096;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 13'd8191;
    localparam logic signed [SUM_W-1:0] SUM_HI = 28'sd8388607;
    localparam logic signed [SUM_W-1:0] SUM_LO = -28'sd8388608;
    localparam logic signed [COEF_W-1:0] COEF_ONE = 10'sd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN   = 2'd0,
        REG_THRESH = 2'd1,
        REG_GREEN  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic capture;
        logic mul_en;
        logic sum_en;
        logic lvl_en;
        logic tgt_en;
        logic emit;
    } alm_cmd_t;

    typedef struct packed {
        logic out_free;
        logic last;
    } alm_sts_t;

endpackage

`default_nettype wire

// ----- design/alm_ctrl.sv -----
// Controller of the audio level bar meter: sequences one sample through
// filter, level and scaling steps, then paces the pixel words. Uses alm_pkg.
`default_nettype none

module alm_ctrl
    import alm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    output alm_cmd_t      cmd,
    input  wire alm_sts_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_LVL,
        ST_TGT,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = ST_LVL;
            end
            ST_LVL:
            begin
                cmd.lvl_en = 1'b1;
                state_next = ST_TGT;
            end
            ST_TGT:
            begin
                cmd.tgt_en = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.emit = sts.out_free;
                if (sts.out_free && sts.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

// ----- design/alm_dp.sv -----
// Datapath of the audio level bar meter: configuration registers, Q8
// average filter, level and bar scaling, pixel output register. Uses alm_pkg.
`default_nettype none

module alm_dp
    import alm_pkg::*;
#(
    parameter int PIXELS = PIXELS_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire alm_cmd_t              cmd,
    output alm_sts_t                   sts,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [SAMPLE_W-1:0]   sample,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [WORD_W-1:0]          pixel_word,
    output logic [INDEX_W-1:0]         pixel_index,
    output logic [LEVEL_W-1:0]         level,
    output logic                       last_pixel
);

    localparam int PIX_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int ACC_W = DIV_W + $clog2(PIXELS + 1);

    // configuration
    logic [GAIN_W-1:0]  gain_reg;
    logic [THR_W-1:0]   thr_reg;
    logic [GREEN_W-1:0] green_reg;

    // filter
    logic [SAMPLE_W-1:0]        sample_reg;
    logic [PROD_A_W-1:0]        prod_a_reg;
    logic signed [PROD_B_W-1:0] prod_b_reg;
    logic signed [COEF_W-1:0]   coef;
    logic signed [SUM_W-1:0]    sum;
    logic signed [AVG_W-1:0]    avg_reg;
    logic signed [AVG_W-1:0]    avg_next;

    // level and scaling
    logic signed [AVG_W-8:0]    diff;
    logic [LEVEL_W-1:0]         level_reg;
    logic [LEVEL_W-1:0]         level_next;
    logic [ACC_W-1:0]           target_reg;
    logic [DIV_W-1:0]           step_reg;
    logic [ACC_W-1:0]           acc_reg;
    logic [PIX_W-1:0]           pix_reg;

    // output register
    logic                       out_valid_reg;
    logic [WORD_W-1:0]          word_reg;
    logic [INDEX_W-1:0]         idx_reg;
    logic [LEVEL_W-1:0]         lvl_out_reg;
    logic                       last_reg;
    logic                       lit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_RESET;
            thr_reg   <= THR_RESET;
            green_reg <= GREEN_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_GAIN:   gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_THRESH: thr_reg   <= cfg_data[THR_W-1:0];
                REG_GREEN:  green_reg <= cfg_data[GREEN_W-1:0];
                default:    ;
            endcase
        end
    end

    assign coef = COEF_ONE - $signed({1'b0, gain_reg});
    assign sum  = SUM_W'(prod_b_reg >>> 8) + SUM_W'(prod_a_reg);

    always_comb
    begin
        if (sum > SUM_HI)
        begin
            avg_next = AVG_W'(SUM_HI);
        end
        else if (sum < SUM_LO)
        begin
            avg_next = AVG_W'(SUM_LO);
        end
        else
        begin
            avg_next = sum[AVG_W-1:0];
        end
    end

    // whole part of the average minus the threshold, clamped to 0..8191
    assign diff = {avg_reg[AVG_W-1], avg_reg[AVG_W-1:8]} - $signed({5'b0, thr_reg});

    always_comb
    begin
        if (diff[AVG_W-8])
        begin
            level_next = '0;
        end
        else if (diff[AVG_W-9:LEVEL_W] != '0)
        begin
            level_next = LEVEL_MAX;
        end
        else
        begin
            level_next = diff[LEVEL_W-1:0];
        end
    end

    // pixel i is lit when (i+1)*(4096-thr) <= level*PIXELS
    assign lit = (acc_reg <= target_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg <= '0;
        end
        else if (cmd.sum_en)
        begin
            avg_reg <= avg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= sample;
        end
        if (cmd.mul_en)
        begin
            prod_a_reg <= gain_reg * sample_reg;
            prod_b_reg <= coef * avg_reg;
        end
        if (cmd.lvl_en)
        begin
            level_reg <= level_next;
        end
        if (cmd.tgt_en)
        begin
            target_reg <= ACC_W'(level_reg) * ACC_W'(PIXELS);
            step_reg   <= FULL_SCALE - {1'b0, thr_reg};
            acc_reg    <= ACC_W'(FULL_SCALE - {1'b0, thr_reg});
            pix_reg    <= '0;
        end
        else if (cmd.emit && !sts.last)
        begin
            acc_reg <= acc_reg + ACC_W'(step_reg);
            pix_reg <= pix_reg + 1'b1;
        end
        if (cmd.emit)
        begin
            word_reg    <= lit ? {green_reg, 24'd0} : '0;
            idx_reg     <= INDEX_W'(pix_reg);
            lvl_out_reg <= level_reg;
            last_reg    <= sts.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.out_free = !out_valid_reg || !out_stall;
    assign sts.last     = (pix_reg == PIX_W'(PIXELS - 1));

    assign out_valid   = out_valid_reg;
    assign pixel_word  = word_reg;
    assign pixel_index = idx_reg;
    assign level       = lvl_out_reg;
    assign last_pixel  = last_reg;

endmodule

`default_nettype wire

// ----- design/audio_level_bar_meter.sv -----
// Audio level bar meter: for each microphone sample, update a Q8 moving
// average and emit one GRB word per pixel of the bar.
// Usage:
//   Input channel (in_valid/in_stall, sample): one 12-bit sample per item.
//   Output channel (out_valid/out_stall): PIXELS items per sample, pixel 0
//   first, each with pixel_word, pixel_index, level and last_pixel; last_pixel
//   marks the final word of the sample.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 gain
//   in Q8, 1 noise threshold, 2 green byte; other indexes are ignored.
//   Write it only while no sample is in flight. cfg_ready is always high.
// Timing: a sample is taken one item at a time. After acceptance the filter
//   multiply, sum/saturate, level and bar scaling steps run in turn; then
//   the first word is loaded into the output register, and after it one
//   word per cycle while out_stall is low. The controller walks an idle
//   state that takes the sample, the four steps and an emit state that
//   loads the pixel words.
//   in_stall rises while a sample is being processed and drops as the final
//   word is loaded, so the next sample may enter while that word still waits.
// Stall: out_stall holds the output register and pauses the pixel sequence.
// Reset: the average clears to zero, registers take their defaults
//   (gain 358, threshold 2000, green 127) and both channels go idle.
`default_nettype none

module audio_level_bar_meter
    import alm_pkg::*;
#(
    parameter int PIXELS = PIXELS_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [SAMPLE_W-1:0]   sample,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [WORD_W-1:0]          pixel_word,
    output logic [INDEX_W-1:0]         pixel_index,
    output logic [LEVEL_W-1:0]         level,
    output logic                       last_pixel,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    alm_cmd_t cmd;
    alm_sts_t sts;

    // registers are always writable
    assign cfg_ready = 1'b1;

    // sequence the steps of one sample and pace the pixel words
    alm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    // filter, scaling and the output register
    alm_dp #(
        .PIXELS (PIXELS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_word  (pixel_word),
        .pixel_index (pixel_index),
        .level       (level),
        .last_pixel  (last_pixel)
    );

    // the final word of a sample sits at the last bar position
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_pixel |-> pixel_index == INDEX_W'(PIXELS - 1))
        else $error("last pixel at wrong index");

    // a zero level lights nothing
    a_dark_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && level == '0 |-> pixel_word == '0)
        else $error("pixel lit at zero level");

    // accepting a sample makes the input busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after accepting a sample");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the audio level bar meter.
// Depends on alm_pkg and audio_level_bar_meter; runs a directed table, then
// random phases, and checks every pixel item against its own Q8 filter model.
module tb_top
    import alm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPIX        = PIXELS_DEFAULT;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 50;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 40;
    localparam int SHOW_MAX    = 10;

    // Signed bounds of the 24-bit Q8 average and the level ceiling.
    localparam longint AVG_HI  = 64'sd8388607;
    localparam longint AVG_LO  = -64'sd8388608;
    localparam longint LVL_TOP = 64'sd8191;
    localparam int     SCALE   = 4096;

    // Index 3 lies past the register list; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum logic {
        ROW_WRITE,
        ROW_SAMPLE
    } row_kind_t;

    // One directed step. Index and data matter on write rows only; sample,
    // typed flag, level and lit count on sample rows only.
    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [SAMPLE_W-1:0]    smp;
        logic                   typed;
        logic [LEVEL_W-1:0]     lvl;
        logic [5:0]             lit;
    } dir_row_t;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [INDEX_W-1:0] index;
        logic [LEVEL_W-1:0] lvl;
        logic               last;
    } pixel_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [SAMPLE_W-1:0]   sample;
    logic                  out_valid;
    logic                  out_stall;
    logic [WORD_W-1:0]     pixel_word;
    logic [INDEX_W-1:0]    pixel_index;
    logic [LEVEL_W-1:0]    level;
    logic                  last_pixel;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Mirror of the block's registers and filter state.
    logic [GAIN_W-1:0]         gain_r;
    logic [THR_W-1:0]          thr_r;
    logic [GREEN_W-1:0]        green_r;
    logic signed [AVG_W-1:0]   avg_q8;

    pixel_t pixel_q[$];     // pixel items still owed by the block, oldest first
    int     n_bad    = 0;
    bit     idle_on  = 1'b1; // random gaps on both channels
    bit     hold_req = 1'b0; // asks the output side for one long hold
    bit     offering = 1'b0; // in_valid is meant to be high
    bit     writing  = 1'b0; // cfg_valid is meant to be high

    // Directed table. Expected level and lit count are typed in where they are
    // plain to see; the remaining rows fall back on the filter model.
    dir_row_t dir_rows [26] = '{
        // defaults after reset: zero average and zero sample give a dark bar
        '{ROW_SAMPLE, REG_GAIN,   12'h000, 12'd0,    1'b1, 13'd0,    6'd0},
        '{ROW_SAMPLE, REG_GAIN,   12'h000, 12'd4095, 1'b0, 13'd0,    6'd0},
        '{ROW_SAMPLE, REG_GAIN,   12'h000, 12'd2048, 1'b0, 13'd0,    6'd0},
        '{ROW_SAMPLE, REG_GAIN,   12'h000, 12'd0,    1'b0, 13'd0,    6'd0},
        // unity gain, zero threshold, full green (upper data bits masked off)
        '{ROW_WRITE,  REG_GAIN,   12'h100, 12'd0,    1'b0, 13'd0,    6'd0},
        '{ROW_WRITE,  REG_THRESH, 12'h000, 12'd0,    1'b0, 13'd0,    6'd0},
        '{ROW_WRITE,  REG_GREEN,  12'hFFF, 12'd0,    1'b0, 13'd0,    6'd0},
        '{ROW_SAMPLE, REG_GAIN,   12'h000, 12'd4095, 1'b1, 13'd4095, 6'd24},
        '{ROW_SAMPLE, REG_GAIN,   12'h000, 12'd0,    1'b1, 13'd0,    6'd0},
        // top threshold: average lands exactly on it, divisor of one
        '{ROW_WRITE,  REG_THRESH, 12'hFFF, 12'd0,    1'b0, 13'd0,    6'd0},
        '{ROW_SAMPLE, REG_GAIN,   12'h000, 12'd4095, 1'b1, 13'd0,    6'd0},
        // top gain, spare index ignored; swing the average into saturation
        '{ROW_WRITE,  REG_GAIN,   12'hFFF, 12'd0,    1'b0, 13'd0,    6'd0},
        '{ROW_WRITE,  REG_SPARE,  12'h000, 12'd0,    1'b0, 13'd0,    6'd0},
        '{ROW_SAMPLE, REG_GAIN,   12'h000, 12'd0,    1'b1, 13'd0,    6'd0},
        '{ROW_SAMPLE, REG_GAIN,   12'h000, 12'd4095, 1'b0, 13'd0,    6'd0},
        '{ROW_SAMPLE, REG_GAIN,   12'h000, 12'd0,    1'b0, 13'd0,    6'd0},
        '{ROW_SAMPLE, REG_GAIN,   12'h000, 12'd4095, 1'b0, 13'd0,    6'd0},
        '{ROW_SAMPLE, REG_GAIN,   12'h000, 12'd0,    1'b0, 13'd0,    6'd0},
        '{ROW_SAMPLE, REG_GAIN,   12'h000, 12'd4095, 1'b0, 13'd0,    6'd0},
        '{ROW_SAMPLE, REG_GAIN,   12'h000, 12'd0,    1'b0, 13'd0,    6'd0},
        '{ROW_SAMPLE, REG_GAIN,   12'h000, 12'd4095, 1'b0, 13'd0,    6'd0},
        '{ROW_SAMPLE, REG_GAIN,   12'h000, 12'd0,    1'b1, 13'd0,    6'd0},
        '{ROW_SAMPLE, REG_GAIN,   12'h000, 12'd4095, 1'b1, 13'd8191, 6'd25},
        // zero gain holds the saturated average; zero green darkens lit pixels
        '{ROW_WRITE,  REG_GAIN,   12'h000, 12'd0,    1'b0, 13'd0,    6'd0},
        '{ROW_WRITE,  REG_GREEN,  12'h000, 12'd0,    1'b0, 13'd0,    6'd0},
        '{ROW_SAMPLE, REG_GAIN,   12'h000, 12'd4095, 1'b1, 13'd8191, 6'd25}
    };

    reg_idx_t cfg_regs [3] = '{REG_GAIN, REG_THRESH, REG_GREEN};

    audio_level_bar_meter dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void flag_bad(input string msg);
        n_bad++;
        if (n_bad <= SHOW_MAX)
            $display("[%0t] %s", $time, msg);
    endfunction

    // Advance the Q8 average by one sample and derive level and lit count.
    // The arithmetic shift floors toward minus infinity, as the filter needs.
    function automatic void filter_step(input logic [SAMPLE_W-1:0] s,
                                        output logic [LEVEL_W-1:0] lvl,
                                        output int lit);
        longint g;
        longint mixed;
        longint nxt;
        longint floor_q8;
        longint above;
        g     = longint'(gain_r);
        mixed = (64'sd256 - g) * longint'(avg_q8);
        nxt   = g * longint'(s) + (mixed >>> 8);
        if (nxt > AVG_HI)
            nxt = AVG_HI;
        if (nxt < AVG_LO)
            nxt = AVG_LO;
        avg_q8   = nxt[AVG_W-1:0];
        floor_q8 = longint'(thr_r) * 256;
        lvl      = '0;
        if (nxt >= floor_q8)
        begin
            above = (nxt - floor_q8) >>> 8;
            lvl   = (above > LVL_TOP) ? LVL_TOP[LEVEL_W-1:0] : above[LEVEL_W-1:0];
        end
        lit = int'(lvl) * NPIX / (SCALE - int'(thr_r));
        if (lit > NPIX)
            lit = NPIX;
    endfunction

    // Register data for one phase: defaults first, then extremes or random.
    function automatic logic [CFG_DATA_W-1:0] phase_setting(input reg_idx_t r,
                                                            input int ph);
        if (ph == 0)
        begin
            case (r)
                REG_GAIN:   return CFG_DATA_W'(GAIN_RESET);
                REG_THRESH: return CFG_DATA_W'(THR_RESET);
                default:    return CFG_DATA_W'(GREEN_RESET);
            endcase
        end
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return CFG_DATA_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // Mostly uniform samples, some rail values, some right around the threshold.
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int unsigned mode;
        int          near;
        mode = $urandom_range(0, 9);
        if (mode < 6)
            return SAMPLE_W'($urandom_range(0, 4095));
        if (mode == 6)
            return '0;
        if (mode == 7)
            return '1;
        near = int'(thr_r) + int'($urandom_range(0, 20)) - 10;
        if (near < 0)
            near = 0;
        if (near > 4095)
            near = 4095;
        return SAMPLE_W'(near);
    endfunction

    // Write one register and mirror it once the write is taken.
    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        writing    = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_GAIN:   gain_r  = data[GAIN_W-1:0];
            REG_THRESH: thr_r   = data[THR_W-1:0];
            REG_GREEN:  green_r = data[GREEN_W-1:0];
            default:    ;
        endcase
    endtask

    // Offer one sample, hold it until taken, then queue its pixel items.
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic typed,
                               input logic [LEVEL_W-1:0] t_lvl, input int t_lit);
        logic [LEVEL_W-1:0] lvl;
        int                 lit;
        pixel_t             px;
        if (writing)
        begin
            cfg_valid <= 1'b0;
            writing    = 1'b0;
        end
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            if (offering)
            begin
                in_valid <= 1'b0;
                offering  = 1'b0;
            end
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= s;
        offering  = 1'b1;
        do @(posedge clk); while (in_stall);
        filter_step(s, lvl, lit);
        // Typed rows override the model's numbers; the average still advances.
        if (typed)
        begin
            lvl = t_lvl;
            lit = t_lit;
        end
        for (int i = 0; i < NPIX; i++)
        begin
            px.word  = (i < lit) ? {green_r, {(WORD_W-GREEN_W){1'b0}}} : '0;
            px.index = INDEX_W'(i);
            px.lvl   = lvl;
            px.last  = (i == NPIX - 1);
            pixel_q.push_back(px);
        end
    endtask

    // Drop the input valid and wait until every owed pixel item is out.
    task automatic settle_block();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering  = 1'b0;
        end
        while (pixel_q.size() != 0)
            @(posedge clk);
    endtask

    // Output side: check each taken item, then pick next cycle's stall.
    // Stalls come in short random bursts, plus one long hold on request so
    // the block backs up and stalls its own input.
    initial
    begin
        int     stall_left;
        pixel_t want;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (pixel_q.size() == 0)
                    flag_bad($sformatf({"unexpected pixel item: word %h index %0d",
                                        " level %0d last %0b"},
                                       pixel_word, pixel_index, level, last_pixel));
                else
                begin
                    want = pixel_q.pop_front();
                    if (pixel_word !== want.word || pixel_index !== want.index ||
                        level !== want.lvl || last_pixel !== want.last)
                        flag_bad($sformatf({"pixel mismatch: expected word %h index %0d",
                                            " level %0d last %0b, got word %h index %0d",
                                            " level %0d last %0b"},
                                           want.word, want.index, want.lvl, want.last,
                                           pixel_word, pixel_index, level, last_pixel));
                end
            end
            if (hold_req)
            begin
                stall_left = LONG_HOLD;
                hold_req   = 1'b0;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0)
                stall_left = $urandom_range(1, 9);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Input side: reset, directed table, random phases, wrap-up.
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        sample    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        gain_r    = GAIN_RESET;
        thr_r     = THR_RESET;
        green_r   = GREEN_RESET;
        avg_q8    = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table; registers change only with nothing in flight.
        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind == ROW_WRITE)
            begin
                settle_block();
                apply_write(dir_rows[r].idx, dir_rows[r].data);
            end
            else
                send_sample(dir_rows[r].smp, dir_rows[r].typed, dir_rows[r].lvl,
                            int'(dir_rows[r].lit));
        end

        // Random phases, each with fresh register settings. The block is
        // drained first, so the sender pauses for every owed item each time.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle_block();
            idle_on = (ph != PHASES - 1);
            foreach (cfg_regs[k])
                apply_write(cfg_regs[k], phase_setting(cfg_regs[k], ph));
            if ($urandom_range(0, 2) == 0)
                apply_write(REG_SPARE, CFG_DATA_W'($urandom_range(0, 4095)));
            if (ph == 2)
                hold_req = 1'b1;
            repeat (PHASE_ITEMS)
                send_sample(pick_sample(), 1'b0, '0, 0);
        end

        settle_block();
        repeat (SETTLE) @(posedge clk);
        n_bad += pixel_q.size();
        if (n_bad == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
